/* hdl/column_sample_variance_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the column sample variance core
// Concurrent checks on clk_i with rst_ni low as disable; empty when SYNTH set.
// ----------------------------------------------------------------------------
`ifndef COLUMN_SAMPLE_VARIANCE_CORE_MACROS_SVH
`define COLUMN_SAMPLE_VARIANCE_CORE_MACROS_SVH

`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define CSV_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("column sample variance assertion failed");
// Antecedent in one cycle implies consequent in the next.
`define CSV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("column sample variance assertion failed");
`else
`define CSV_ASSERT(lbl, prop)
`define CSV_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* hdl/csv_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_pkg
// Widths, column summary type and back-end state codes for the core.
// ----------------------------------------------------------------------------
package csv_pkg;

  localparam int MAX_ROWS = 4096;
  localparam int VAL_W    = 16;
  localparam int CTR_W    = 24;
  localparam int FRAC_C   = CTR_W - VAL_W;          // fraction bits of the center
  localparam int CNT_W    = $clog2(MAX_ROWS + 1);
  localparam int SUM_W    = 29;
  localparam int MAG_W    = SUM_W - 1;
  localparam int SS_W     = 2 * MAG_W;
  localparam int SQ_W     = 64;
  localparam int SQ_HALF  = SQ_W / 2;
  localparam int FRAC_W   = 16;
  localparam int VAR_W    = 50;
  localparam int DIV_W    = SQ_W + FRAC_W;
  localparam int ITER_W   = $clog2(DIV_W);
  localparam int DEN_W    = $clog2(MAX_ROWS * (MAX_ROWS - 1) + 1);
  localparam int XW       = CTR_W + 1;
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_MISSING = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_USE_CENTER   = CFG_IDX_W'(1);

  localparam logic [VAR_W-1:0] VAR_MAX = {VAR_W{1'b1}};

  typedef struct packed {
    logic                    use_center;
    logic                    undef;
    logic [CNT_W-1:0]        count;
    logic signed [SUM_W-1:0] sum;
    logic [SQ_W-1:0]         sq;
  } col_sum_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL_LO,
    BK_MUL_HI,
    BK_SUB,
    BK_DIV,
    BK_OUT
  } bk_state_e;

endpackage

/* hdl/csv_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_front
// Per-element accumulation of count, sum and sum of squares; emits a column
// summary when the last element of a column is transferred.
// ----------------------------------------------------------------------------
`include "column_sample_variance_core_macros.svh"

module csv_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            accept_i,
  input  logic signed [csv_pkg::VAL_W-1:0] sample_value_i,
  input  logic                            is_missing_i,
  input  logic signed [csv_pkg::CTR_W-1:0] center_value_i,
  input  logic                            last_in_column_i,
  input  logic                            skip_missing_i,
  input  logic                            use_center_i,
  output logic                            push_o,
  output csv_pkg::col_sum_t               summary_o
);

  logic [csv_pkg::CNT_W-1:0]        count_q, count_d;
  logic signed [csv_pkg::SUM_W-1:0] sum_q, sum_d;
  logic [csv_pkg::SQ_W-1:0]         sq_q, sq_d;
  logic signed [csv_pkg::CTR_W-1:0] held_q, ctr;
  logic                             miss_q, miss_d;
  logic                             started_q;
  logic                             counted;
  logic signed [csv_pkg::XW-1:0]    x;
  logic signed [2*csv_pkg::XW-1:0]  prod;

  // First element of a column supplies the center.
  assign ctr = started_q ? held_q : center_value_i;

  always_comb begin
    if (use_center_i) begin
      x = csv_pkg::XW'($signed({sample_value_i, {csv_pkg::FRAC_C{1'b0}}}))
          - csv_pkg::XW'(ctr);
    end else begin
      x = csv_pkg::XW'(sample_value_i);
    end
  end

  assign prod = x * x;

  assign counted = !is_missing_i && (count_q < csv_pkg::CNT_W'(csv_pkg::MAX_ROWS));
  assign count_d = counted ? count_q + csv_pkg::CNT_W'(1) : count_q;
  assign sum_d   = counted ? sum_q + csv_pkg::SUM_W'(sample_value_i) : sum_q;
  assign sq_d    = counted ? sq_q + csv_pkg::SQ_W'($unsigned(prod)) : sq_q;
  assign miss_d  = miss_q | (is_missing_i & ~skip_missing_i);

  assign push_o = accept_i && last_in_column_i;

  always_comb begin
    summary_o.use_center = use_center_i;
    summary_o.undef      = miss_d || (count_d < csv_pkg::CNT_W'(2));
    summary_o.count      = count_d;
    summary_o.sum        = sum_d;
    summary_o.sq         = sq_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      sum_q     <= '0;
      sq_q      <= '0;
      held_q    <= '0;
      miss_q    <= 1'b0;
      started_q <= 1'b0;
    end else if (accept_i) begin
      if (last_in_column_i) begin
        count_q   <= '0;
        sum_q     <= '0;
        sq_q      <= '0;
        held_q    <= '0;
        miss_q    <= 1'b0;
        started_q <= 1'b0;
      end else begin
        count_q   <= count_d;
        sum_q     <= sum_d;
        sq_q      <= sq_d;
        held_q    <= ctr;
        miss_q    <= miss_d;
        started_q <= 1'b1;
      end
    end
  end

  `CSV_ASSERT(a_count_bound, count_q <= csv_pkg::CNT_W'(csv_pkg::MAX_ROWS))
  `CSV_ASSERT_NEXT(a_clear_after_last, push_o, (count_q == '0) && !started_q && !miss_q)

endmodule

/* hdl/csv_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_queue
// Short FIFO of column summaries between the accumulator and the divider.
// ----------------------------------------------------------------------------
`include "column_sample_variance_core_macros.svh"

module csv_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  csv_pkg::col_sum_t data_i,
  input  logic              pop_i,
  output csv_pkg::col_sum_t data_o,
  output logic              empty_o,
  output logic              full_o
);

  csv_pkg::col_sum_t              mem [csv_pkg::QDEPTH];
  logic [csv_pkg::QPTR_W-1:0]     wr_q, rd_q;
  logic [csv_pkg::QPTR_W:0]       fill_q;

  assign empty_o = (fill_q == '0);
  assign full_o  = (fill_q == (csv_pkg::QPTR_W+1)'(csv_pkg::QDEPTH));
  assign data_o  = mem[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == csv_pkg::QPTR_W'(csv_pkg::QDEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == csv_pkg::QPTR_W'(csv_pkg::QDEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   fill_q <= fill_q + 1'b1;
        2'b01:   fill_q <= fill_q - 1'b1;
        default: fill_q <= fill_q;
      endcase
    end
  end

  `CSV_ASSERT(a_no_push_full, !(push_i && full_o))
  `CSV_ASSERT(a_no_pop_empty, !(pop_i && empty_o))

endmodule

/* hdl/csv_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_back
// Finishes one column: forms the corrected sum of squares with split
// multiplies (non-centered mode only), then runs a bit-serial restoring divide and holds the result.
// ----------------------------------------------------------------------------
`include "column_sample_variance_core_macros.svh"

module csv_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        col_valid_i,
  input  csv_pkg::col_sum_t           col_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [csv_pkg::VAR_W-1:0]   variance_q16_o,
  output logic                        result_undefined_o
);

  csv_pkg::bk_state_e state_q, state_d;

  logic                              centered_q, undef_q;
  logic [csv_pkg::CNT_W-1:0]         n_q;
  logic [csv_pkg::SQ_W-1:0]          sq_q, ns2_q;
  logic [csv_pkg::MAG_W-1:0]         mag_q;
  logic [csv_pkg::SS_W-1:0]          ss_q;
  logic [csv_pkg::DEN_W-1:0]         den_q;
  logic [csv_pkg::DIV_W-1:0]         dvd_q;
  logic [csv_pkg::DEN_W-1:0]         rem_q;
  logic [csv_pkg::VAR_W-1:0]         quot_q;
  logic                              ovf_q;
  logic [csv_pkg::ITER_W-1:0]        iter_q;

  logic [csv_pkg::SUM_W-1:0]         sum_abs;
  logic [csv_pkg::CNT_W+csv_pkg::SQ_HALF-1:0] prod_lo, prod_hi;
  logic [2*csv_pkg::CNT_W-1:0]       nn;
  logic [csv_pkg::SQ_W-1:0]          ss_ext, corr;
  logic [csv_pkg::DEN_W:0]           trial, diff;
  logic                              ge;

  assign sum_abs = col_i.sum[csv_pkg::SUM_W-1] ? csv_pkg::SUM_W'(-col_i.sum)
                                                : csv_pkg::SUM_W'(col_i.sum);
  assign prod_lo = n_q * sq_q[csv_pkg::SQ_HALF-1:0];
  assign prod_hi = n_q * sq_q[csv_pkg::SQ_W-1:csv_pkg::SQ_HALF];
  assign nn      = (2*csv_pkg::CNT_W)'(n_q) * (2*csv_pkg::CNT_W)'(n_q - csv_pkg::CNT_W'(1));
  assign ss_ext  = csv_pkg::SQ_W'(ss_q);
  // Clamp at zero when the wrapped product falls below the squared sum.
  assign corr    = (ns2_q > ss_ext) ? ns2_q - ss_ext : '0;

  assign trial = {rem_q, dvd_q[csv_pkg::DIV_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= csv_pkg::BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    pop_o       = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      csv_pkg::BK_IDLE: begin
        if (col_valid_i) begin
          pop_o   = 1'b1;
          state_d = col_i.undef ? csv_pkg::BK_OUT : csv_pkg::BK_MUL_LO;
        end
      end
      csv_pkg::BK_MUL_LO: state_d = csv_pkg::BK_MUL_HI;
      csv_pkg::BK_MUL_HI: state_d = csv_pkg::BK_SUB;
      csv_pkg::BK_SUB:    state_d = csv_pkg::BK_DIV;
      csv_pkg::BK_DIV: begin
        if (iter_q == '0) begin
          state_d = csv_pkg::BK_OUT;
        end
      end
      csv_pkg::BK_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = csv_pkg::BK_IDLE;
        end
      end
      default: state_d = csv_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      csv_pkg::BK_IDLE: begin
        if (col_valid_i) begin
          centered_q <= col_i.use_center;
          undef_q    <= col_i.undef;
          n_q        <= col_i.count;
          sq_q       <= col_i.sq;
          mag_q      <= sum_abs[csv_pkg::MAG_W-1:0];
        end
      end
      csv_pkg::BK_MUL_LO: begin
        ns2_q <= csv_pkg::SQ_W'(prod_lo);
        ss_q  <= mag_q * mag_q;
        den_q <= centered_q ? csv_pkg::DEN_W'(n_q - csv_pkg::CNT_W'(1))
                            : nn[csv_pkg::DEN_W-1:0];
      end
      csv_pkg::BK_MUL_HI: begin
        ns2_q <= ns2_q + {prod_hi[csv_pkg::SQ_HALF-1:0], {csv_pkg::SQ_HALF{1'b0}}};
      end
      csv_pkg::BK_SUB: begin
        dvd_q  <= centered_q ? csv_pkg::DIV_W'(sq_q) : {corr, {csv_pkg::FRAC_W{1'b0}}};
        rem_q  <= '0;
        quot_q <= '0;
        ovf_q  <= 1'b0;
        iter_q <= csv_pkg::ITER_W'(csv_pkg::DIV_W - 1);
      end
      csv_pkg::BK_DIV: begin
        dvd_q  <= {dvd_q[csv_pkg::DIV_W-2:0], 1'b0};
        rem_q  <= ge ? diff[csv_pkg::DEN_W-1:0] : trial[csv_pkg::DEN_W-1:0];
        quot_q <= {quot_q[csv_pkg::VAR_W-2:0], ge};
        ovf_q  <= ovf_q | quot_q[csv_pkg::VAR_W-1];
        iter_q <= iter_q - 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign result_undefined_o = undef_q;
  assign variance_q16_o     = undef_q ? '0 : (ovf_q ? csv_pkg::VAR_MAX : quot_q);

  `CSV_ASSERT(a_undef_zero, !(out_valid_o && result_undefined_o) || (variance_q16_o == '0))
  `CSV_ASSERT_NEXT(a_div_exit, state_q == csv_pkg::BK_DIV, (state_q == csv_pkg::BK_DIV) || (state_q == csv_pkg::BK_OUT))

endmodule

/* hdl/column_sample_variance_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// column_sample_variance_core
// Streaming sample variance of one matrix column, one element per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one column element per
//   transfer; last_in_column_i closes the column and yields one result on the
//   output channel (out_valid_o / out_ready_i). Other elements yield nothing.
//   Configuration writes (cfg_valid_i / cfg_ready_o) set skip_missing at
//   index 0 and use_center at index 1; other indexes are dropped. Write them
//   only while the core is idle.
//   Throughput: one element per cycle. in_ready_o drops only while the
//   two-entry summary queue is full.
//   A defined result passes through the split multiplies, the subtraction and
//   the bit-serial divide, one quotient bit per cycle over an 80-bit
//   dividend; an undefined one goes straight to the output. The back end
//   takes the next summary only after the current result is taken.
//   Reset clears both configuration registers, the accumulators and the queue.
//   A stalled receiver holds the result; the accumulator keeps taking
//   elements until the queue fills.
// ----------------------------------------------------------------------------

module column_sample_variance_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [csv_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [csv_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [csv_pkg::VAL_W-1:0]    sample_value_i,
  input  logic                                is_missing_i,
  input  logic signed [csv_pkg::CTR_W-1:0]    center_value_i,
  input  logic                                last_in_column_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [csv_pkg::VAR_W-1:0]           variance_q16_o,
  output logic                                result_undefined_o
);

  logic              skip_missing_q, use_center_q;
  logic              accept, push, pop, q_empty, q_full;
  csv_pkg::col_sum_t summary, head;

  // Configuration is always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_missing_q <= 1'b0;
      use_center_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        csv_pkg::CFG_SKIP_MISSING: skip_missing_q <= cfg_data_i[0];
        csv_pkg::CFG_USE_CENTER:   use_center_q   <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // Hold off new elements only when a column summary would find no room.
  assign in_ready_o = !q_full;
  assign accept     = in_valid_i && in_ready_o;

  csv_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .sample_value_i   (sample_value_i),
    .is_missing_i     (is_missing_i),
    .center_value_i   (center_value_i),
    .last_in_column_i (last_in_column_i),
    .skip_missing_i   (skip_missing_q),
    .use_center_i     (use_center_q),
    .push_o           (push),
    .summary_o        (summary)
  );

  csv_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (summary),
    .pop_i   (pop),
    .data_o  (head),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // Back end drains one summary at a time and holds the result until taken.
  csv_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .col_valid_i        (!q_empty),
    .col_i              (head),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .variance_q16_o     (variance_q16_o),
    .result_undefined_o (result_undefined_o)
  );

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for column_sample_variance_core. Streams columns through
// the element channel under several mode and flow-control settings, predicts
// each column result with a cycle-free software model of the accumulator, and
// compares every result transfer against the oldest prediction.
// ----------------------------------------------------------------------------

module tb_top;

  import csv_pkg::*;

  // Run-length knobs
  localparam int RANDOM_ITEMS  = 430;
  localparam int PHASES        = 4;
  localparam int WRAP_ROWS     = 512;
  localparam int SETTLE_CYCLES = DIV_W + 20;      // covers a full pass of the back end
  localparam int DRAIN_LIMIT   = 20000;
  localparam int HOLD_CYCLES   = 300;
  localparam int TIMEOUT_NS    = 1_000_000;
  localparam int REPORT_LIMIT  = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_USE_CENTER + 1'b1;

  typedef struct packed {
    logic [VAR_W-1:0] var_q16;
    logic             undef;
  } var_result_t;

  // DUT ports; inputs driven to known values from time zero
  logic                    clk_i            = 1'b0;
  logic                    rst_ni           = 1'b0;
  logic                    cfg_valid_i      = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i      = '0;
  logic [CFG_DATA_W-1:0]   cfg_data_i       = '0;
  logic                    in_valid_i       = 1'b0;
  logic                    in_ready_o;
  logic signed [VAL_W-1:0] sample_value_i   = '0;
  logic                    is_missing_i     = 1'b0;
  logic signed [CTR_W-1:0] center_value_i   = '0;
  logic                    last_in_column_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_ready_i      = 1'b0;
  logic [VAR_W-1:0]        variance_q16_o;
  logic                    result_undefined_o;

  // Flow-control knobs, changed by the test tasks
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_request   = 1'b0;
  int unsigned hold_left      = 0;

  // Mirror of the configuration registers
  bit skip_missing_m = 1'b0;
  bit use_center_m   = 1'b0;

  // Mirror of the column accumulator
  int unsigned elem_count  = 0;
  longint      col_sum     = 0;
  bit [63:0]   col_sq      = '0;
  int          col_center  = 0;
  bit          col_missing = 1'b0;
  bit          col_started = 1'b0;

  var_result_t pending_variance[$];

  // Random column generator state, kept across phases so a column can span
  // a mode change
  int unsigned col_left = 0;

  // Statistics and error tally
  int unsigned error_count     = 0;
  int unsigned elements_sent   = 0;
  int unsigned results_seen    = 0;
  int unsigned undefined_seen  = 0;
  int unsigned saturated_seen  = 0;

  column_sample_variance_core u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .sample_value_i     (sample_value_i),
    .is_missing_i       (is_missing_i),
    .center_value_i     (center_value_i),
    .last_in_column_i   (last_in_column_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .variance_q16_o     (variance_q16_o),
    .result_undefined_o (result_undefined_o)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Final divide of a closed column under the mode in force on its last
  // element. The non-centered path forms n*sum(v^2) - sum(v)^2 with the
  // product wrapping at 64 bits; a negative spread clamps to zero.
  function automatic logic [VAR_W-1:0] column_variance(bit [63:0] n);
    bit [63:0] sum_mag;
    bit [63:0] sum_sq;
    bit [63:0] scaled;
    bit [63:0] spread;
    bit [63:0] denom;
    bit [63:0] quo;
    bit [63:0] rem;
    bit [63:0] res;
    if (use_center_m) begin
      res = col_sq / (n - 1);
    end else begin
      sum_mag = (col_sum < 0) ? -col_sum : col_sum;
      sum_sq  = sum_mag * sum_mag;
      scaled  = n * col_sq;
      spread  = (scaled > sum_sq) ? scaled - sum_sq : 64'd0;
      denom   = n * (n - 1);
      quo     = spread / denom;
      rem     = spread % denom;
      // Saturate before the integer part would overflow the result field
      if (quo > (VAR_MAX >> FRAC_W)) return VAR_MAX;
      res = (quo << FRAC_W) + ((rem << FRAC_W) / denom);
    end
    return (res > VAR_MAX) ? VAR_MAX : res[VAR_W-1:0];
  endfunction

  // Fold one accepted element into the mirror; on the closing element queue
  // the expected result and clear the column.
  function automatic void track_variance(logic signed [VAL_W-1:0] v, logic miss,
                                         logic signed [CTR_W-1:0] ctr, logic last);
    longint      dev;
    bit [63:0]   mag;
    var_result_t r;
    // The first element latches the center, missing or not
    if (!col_started) begin
      col_center  = ctr;
      col_started = 1'b1;
    end
    if (miss) begin
      if (!skip_missing_m) col_missing = 1'b1;
    end else if (elem_count < MAX_ROWS) begin
      // Accumulate under the mode in force on this element
      elem_count++;
      col_sum += v;
      if (use_center_m) dev = (longint'(v) <<< FRAC_C) - longint'(col_center);
      else              dev = longint'(v);
      mag     = (dev < 0) ? -dev : dev;
      col_sq += mag * mag;
    end
    if (last) begin
      if (col_missing || elem_count < 2) begin
        r.var_q16 = '0;
        r.undef   = 1'b1;
      end else begin
        r.var_q16 = column_variance(elem_count);
        r.undef   = 1'b0;
      end
      pending_variance.push_back(r);
      elem_count  = 0;
      col_sum     = 0;
      col_sq      = '0;
      col_center  = 0;
      col_missing = 1'b0;
      col_started = 1'b0;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Result side: stall the receiver and check each transfer
  // --------------------------------------------------------------------------

  // Stall at random; on request hold ready low for a long counted stretch so
  // the summary queue fills and the element channel backs up.
  always @(posedge clk_i) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic void log_mismatch(string what, logic [63:0] want_v,
                                       logic [63:0] got_v);
    error_count++;
    if (error_count <= REPORT_LIMIT)
      $display("[%0t] mismatch on %0s: expected 0x%0h, got 0x%0h",
               $time, what, want_v, got_v);
  endfunction

  // Compare each result transfer against the oldest prediction
  always @(posedge clk_i) begin
    var_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (result_undefined_o === 1'b1) undefined_seen++;
      if (variance_q16_o === VAR_MAX) saturated_seen++;
      if (pending_variance.size() == 0) begin
        log_mismatch("unexpected result", 64'd0, {13'd0, result_undefined_o,
                                                  variance_q16_o});
      end else begin
        want = pending_variance.pop_front();
        if (variance_q16_o !== want.var_q16)
          log_mismatch("variance_q16", want.var_q16, variance_q16_o);
        if (result_undefined_o !== want.undef)
          log_mismatch("result_undefined", want.undef, result_undefined_o);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Element and configuration drivers
  // --------------------------------------------------------------------------

  // Offer one element; hold it until transferred, then predict. Valid is
  // dropped only in idle gaps and by wait_idle; back-to-back elements keep it high.
  task automatic push_element(logic signed [VAL_W-1:0] v, logic miss,
                              logic signed [CTR_W-1:0] ctr, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    sample_value_i   <= v;
    is_missing_i     <= miss;
    center_value_i   <= ctr;
    last_in_column_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    elements_sent++;
    track_variance(v, miss, ctr, last);
  endtask

  // Write both mode registers, then one index past the map that must be
  // dropped. Upper data bits carry noise the core must ignore.
  task automatic set_mode(bit skip, bit centered);
    logic [CFG_DATA_W-1:0] word;
    word    = $urandom;
    word[0] = skip;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_SKIP_MISSING;
    cfg_data_i  <= word;
    do @(posedge clk_i); while (!cfg_ready_o);
    skip_missing_m = skip;
    word    = $urandom;
    word[0] = centered;
    cfg_index_i <= CFG_USE_CENTER;
    cfg_data_i  <= word;
    do @(posedge clk_i); while (!cfg_ready_o);
    use_center_m = centered;
    cfg_index_i <= $urandom_range({CFG_IDX_W{1'b1}}, CFG_FIRST_UNUSED);
    cfg_data_i  <= $urandom;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Drop valid, wait for every predicted result, then let the back end settle
  // so a column left open mid-divide cannot see a register change.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    for (int w = 0; w < DRAIN_LIMIT && pending_variance.size() != 0; w++)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One random element of a random-length column. Most columns are short and
  // well formed; a few run long, a few close after one element, and missing
  // elements show up now and then.
  task automatic send_random_element();
    logic signed [VAL_W-1:0] v;
    logic signed [CTR_W-1:0] ctr;
    logic                    miss;
    if (col_left == 0)
      col_left = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
    case ($urandom_range(3))
      0: v = $urandom_range(64) - 32;
      1: begin
        case ($urandom_range(3))
          0: v = {1'b0, {(VAL_W-1){1'b1}}};
          1: v = {1'b1, {(VAL_W-1){1'b0}}};
          2: v = '0;
          default: v = '1;
        endcase
      end
      default: v = $urandom;
    endcase
    // Center either anywhere in range or close to a plausible column mean
    if ($urandom_range(1)) ctr = $urandom;
    else                   ctr = {v, FRAC_C'($urandom)};
    miss = ($urandom_range(19) == 0);
    push_element(v, miss, ctr, col_left == 1);
    col_left--;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Hand-picked columns: field extremes, each mode pair, missing handling
  task automatic test_directed_cases();
    // Reset modes: no skipping, non-centered
    push_element(16'sh7fff, 1'b0, '0, 1'b1);          // one element: undefined
    push_element(16'sh8000, 1'b0, '0, 1'b0);          // widest spread
    push_element(16'sh7fff, 1'b0, '0, 1'b1);
    repeat (3) push_element('0, 1'b0, '0, 1'b0);      // constant column
    push_element('0, 1'b0, '0, 1'b1);
    push_element(16'sd5, 1'b0, '0, 1'b0);             // missing poisons column
    push_element('0, 1'b1, '0, 1'b0);
    push_element(16'sd7, 1'b0, '0, 1'b1);
    wait_idle();

    set_mode(1'b1, 1'b0);
    push_element(16'sd100, 1'b0, '0, 1'b0);           // missing is skipped
    push_element('0, 1'b1, '0, 1'b0);
    push_element(-16'sd100, 1'b0, '0, 1'b1);
    push_element(16'sd1, 1'b0, '0, 1'b0);             // missing element closes
    push_element(16'sd2, 1'b0, '0, 1'b0);
    push_element('0, 1'b1, '0, 1'b1);
    push_element(16'sh7fff, 1'b1, '0, 1'b1);          // nothing counted
    wait_idle();

    set_mode(1'b0, 1'b1);
    push_element(16'sh8000, 1'b0, 24'sh7fffff, 1'b0); // farthest from center
    push_element(16'sh7fff, 1'b0, 24'sh800000, 1'b1); // center already held
    push_element('0, 1'b0, '0, 1'b0);
    push_element('0, 1'b0, '0, 1'b1);
    wait_idle();

    set_mode(1'b1, 1'b1);
    push_element('0, 1'b1, 24'sd2560, 1'b0);          // missing still latches center
    push_element(16'sd10, 1'b0, 24'sh800000, 1'b0);
    push_element(16'sd20, 1'b0, '0, 1'b1);
    wait_idle();
  endtask

  // Centered squares piled up, then the column closes non-centered: the
  // integer part overflows and the result must saturate.
  task automatic test_mode_switch_saturation();
    set_mode(1'b0, 1'b1);
    push_element(16'sh7fff, 1'b0, 24'sh800000, 1'b0);
    push_element(16'sh7fff, 1'b0, $urandom, 1'b0);
    wait_idle();
    set_mode(1'b0, 1'b0);
    push_element('0, 1'b0, $urandom, 1'b1);
    wait_idle();
  endtask

  // Tall column: 512 centered squares of 2^46 make n*sum wrap to zero at
  // n = 512, so the spread clamps to zero. A skipped missing element closes
  // the column under the non-centered mode.
  task automatic test_long_column_wrap();
    send_idle_pct = 24;
    set_mode(1'b1, 1'b1);
    repeat (WRAP_ROWS) push_element('0, 1'b0, 24'sh800000, 1'b0);
    wait_idle();
    set_mode(1'b1, 1'b0);
    push_element(16'sh7fff, 1'b1, $urandom, 1'b1);
    wait_idle();
    send_idle_pct = 0;
  endtask

  // Random columns over four flow-control phases, one mode pair per phase.
  // A column left open at a phase boundary continues under the new mode.
  task automatic test_random_phases();
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      wait_idle();
      set_mode(p[0], p[1]);
      repeat (RANDOM_ITEMS / PHASES) send_random_element();
    end
    // Close whatever column is still open
    while (col_left != 0) send_random_element();
    wait_idle();
  endtask

  // Stop the receiver for a long stretch while short columns keep coming, so
  // the summary queue fills and the element channel must stall.
  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_mode(1'b0, 1'b0);
    hold_request = 1'b1;
    repeat (40) begin
      push_element($urandom, 1'b0, $urandom, 1'b0);
      push_element($urandom, 1'b0, $urandom, 1'b1);
    end
    wait_idle();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_mode_switch_saturation();
    test_long_column_wrap();
    test_random_phases();
    test_output_backpressure();
    wait_idle();

    if (pending_variance.size() != 0) begin
      error_count += pending_variance.size();
      $display("%0d predicted results never arrived", pending_variance.size());
    end
    $display("Streamed %0d elements; checked %0d column results", elements_sent,
             results_seen);
    $display("  %0d undefined, %0d saturated, all four mode pairs, long column",
             undefined_seen, saturated_seen);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run as a failure
  initial begin
    #(TIMEOUT_NS);
    $display("timeout after %0d ns", TIMEOUT_NS);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
